// ===== sv/cli_pkg.sv =====
package cli_pkg;

	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;
	localparam int PIU_W  = 9;
	localparam int IDX_W  = 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_VAL0,
		ST_VAL1,
		ST_VAL2,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic wr;
		logic start;
		logic scan_rd;
		logic rd_hi;
		logic cap_v0;
		logic cap_v1;
		logic div_init;
		logic div_step;
		logic mul;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic flat;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ===== sv/cli_ram.sv =====
module cli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/cli_ctrl.sv =====
module cli_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             op,
	output logic             item_stall,
	input  cli_pkg::status_t sts,
	output cli_pkg::cmd_t    cmd
);

	import cli_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_QUERY) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: state_d = ST_VAL0;
			ST_VAL0:  state_d = ST_VAL1;
			ST_VAL1:  state_d = ST_VAL2;
			ST_VAL2: begin
				state_d = sts.flat ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr    = accept && op == OP_WRITE;
				cmd.start = accept && op == OP_QUERY;
			end
			ST_SCAN:  cmd.scan_rd = 1'b1;
			ST_FLUSH: ;
			ST_VAL0:  ;
			ST_VAL1: begin
				cmd.rd_hi  = 1'b1;
				cmd.cap_v0 = 1'b1;
			end
			ST_VAL2: begin
				cmd.cap_v1   = 1'b1;
				cmd.div_init = 1'b1;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_DONE: cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== sv/cli_dpath.sv =====
module cli_dpath #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cli_pkg::cmd_t                       cmd,
	output cli_pkg::status_t                    sts,
	input  logic                                cfg_we,
	input  logic [cli_pkg::PIU_W-1:0]           cfg_data,
	input  logic [cli_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [cli_pkg::VAL_W-1:0]    axis_point,
	input  logic signed [cli_pkg::VAL_W-1:0]    curve_point,
	input  logic signed [cli_pkg::VAL_W-1:0]    coordinate,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [cli_pkg::VAL_W-1:0]    interpolated_value
);

	import cli_pkg::*;

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int NW    = (CW > PIU_W) ? CW : PIU_W;
	localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
	localparam int DW    = VAL_W + 1;
	localparam int PW    = DW + FRAC_W + 1;
	localparam int SW    = PW - FRAC_W;
	localparam int FCW   = $clog2(FRAC_W);

	logic [PIU_W-1:0]           piu_q;
	logic [NW-1:0]              piu_w;
	logic [NW-1:0]              n_w;
	logic [NW-1:0]              last_w;
	logic [AW-1:0]              last_addr;
	logic [XW-1:0]              idx_ext;
	logic                       wr_en;

	logic [AW-1:0]              idx_q;
	logic [AW-1:0]              idx_s1;
	logic                       cmp_vld_s1;
	logic signed [VAL_W-1:0]    coord_q;
	logic [AW-1:0]              lo_q;
	logic [AW-1:0]              hi_q;
	logic                       have_lo_q;
	logic                       have_hi_q;
	logic signed [VAL_W-1:0]    x0_q;
	logic signed [VAL_W-1:0]    x1_q;
	logic signed [VAL_W-1:0]    v0_q;
	logic signed [VAL_W-1:0]    v1_q;

	logic [AW-1:0]              vaddr;
	logic [AW-1:0]              vaddr0;
	logic [VAL_W-1:0]           axis_rd;
	logic [VAL_W-1:0]           value_rd;
	logic signed [VAL_W-1:0]    axis_s;

	logic [DW-1:0]              rem_q;
	logic [DW-1:0]              den_q;
	logic [DW:0]                rem2;
	logic                       ge;
	logic [FRAC_W-1:0]          quo_q;
	logic [FCW-1:0]             dcnt_q;

	logic signed [DW-1:0]       diff;
	logic signed [FRAC_W:0]     frac_s;
	logic signed [PW-1:0]       prod_q;
	logic signed [SW-1:0]       shifted;
	logic signed [SW:0]         sum;
	logic signed [VAL_W-1:0]    sat;
	logic                       result_valid_q;
	logic signed [VAL_W-1:0]    result_q;

	// point count clamp
	assign piu_w     = NW'(piu_q);
	assign n_w       = (piu_w == '0) ? NW'(1) :
	                   (piu_w > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : piu_w;
	assign last_w    = n_w - NW'(1);
	assign last_addr = last_w[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= PIU_W'(1);
		end else if (cfg_we) begin
			piu_q <= cfg_data;
		end
	end

	assign idx_ext = XW'(entry_index);
	assign wr_en   = cmd.wr && (32'(entry_index) < 32'(TABLE_DEPTH));

	assign vaddr0 = !have_lo_q ? '0 : (!have_hi_q ? last_addr : lo_q);
	assign vaddr  = cmd.rd_hi ? hi_q : vaddr0;

	cli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_axis_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_ext[AW-1:0]),
		.wdata (axis_point),
		.raddr (idx_q),
		.rdata (axis_rd)
	);

	cli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_ext[AW-1:0]),
		.wdata (curve_point),
		.raddr (vaddr),
		.rdata (value_rd)
	);

	assign axis_s = $signed(axis_rd);

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			have_lo_q  <= 1'b0;
			have_hi_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				idx_q     <= '0;
				have_lo_q <= 1'b0;
				have_hi_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) idx_q <= idx_q + AW'(1);
				if (cmp_vld_s1) begin
					if (axis_s <= coord_q) have_lo_q <= 1'b1;
					if (axis_s >= coord_q) have_hi_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.start) begin
			coord_q <= coordinate;
		end
		if (cmp_vld_s1 && !cmd.start) begin
			if (axis_s <= coord_q) begin
				lo_q <= idx_s1;
				x0_q <= axis_s;
			end
			if (!have_hi_q && axis_s >= coord_q) begin
				hi_q <= idx_s1;
				x1_q <= axis_s;
			end
		end
		if (cmd.cap_v0) v0_q <= $signed(value_rd);
		if (cmd.cap_v1) v1_q <= $signed(value_rd);
	end

	// restoring division for the 16-bit fraction
	assign rem2 = {rem_q, 1'b0};
	assign ge   = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= DW'({coord_q[VAL_W-1], coord_q} - {x0_q[VAL_W-1], x0_q});
			den_q  <= DW'({x1_q[VAL_W-1], x1_q} - {x0_q[VAL_W-1], x0_q});
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? DW'(rem2 - {1'b0, den_q}) : rem2[DW-1:0];
			quo_q  <= {quo_q[FRAC_W-2:0], ge};
			dcnt_q <= dcnt_q + FCW'(1);
		end
	end

	assign diff   = DW'({v1_q[VAL_W-1], v1_q} - {v0_q[VAL_W-1], v0_q});
	assign frac_s = $signed({1'b0, quo_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= PW'(diff * frac_s);
	end

	assign shifted = prod_q[PW-1:FRAC_W];
	assign sum     = (SW+1)'({{(SW-VAL_W+1){v0_q[VAL_W-1]}}, v0_q})
	               + (SW+1)'({shifted[SW-1], shifted});

	always_comb begin
		if (sum[SW:VAL_W-1] == '0 || sum[SW:VAL_W-1] == '1) begin
			sat = sum[VAL_W-1:0];
		end else if (sum[SW]) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// coordinate on the upper point of an out-of-order pair gives the full fraction
	always_ff @(posedge clk) begin
		if (cmd.load_out) result_q <= sts.flat ? v0_q : ((coord_q == x1_q) ? v1_q : sat);
	end

	assign sts.scan_last = (idx_q == last_addr);
	assign sts.flat      = !have_lo_q || !have_hi_q || (x0_q >= x1_q);
	assign sts.div_last  = (dcnt_q == FCW'(FRAC_W - 1));
	assign sts.out_free  = !result_valid_q || !result_stall;

	assign result_valid       = result_valid_q;
	assign interpolated_value = result_q;

endmodule

// ===== sv/curve_linear_interpolator.sv =====
// Piecewise linear interpolation over a table of up to TABLE_DEPTH signed Q16.16
// points. A write item (op 0) loads one axis point and curve value. A query
// (op 1) scans the first n table entries, n being points_in_use clamped to
// 1..TABLE_DEPTH, at one entry a cycle through the axis memory's read port,
// then reads the two neighbouring curve values and, unless the result is flat
// (outside the axis range, on a point, or between equal points), runs a 16-step
// restoring division for the fraction and one multiply. The block takes no new
// item until a query is through, and a query's result waits until an earlier
// result has left the output register. The result sits in an output register,
// so the block returns to idle while it waits to be taken. The tables read as
// unknown until written; of the settings, only points_in_use is reset (to 1).
module curve_linear_interpolator #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                op,
	input  logic [cli_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [cli_pkg::VAL_W-1:0]    axis_point,
	input  logic signed [cli_pkg::VAL_W-1:0]    curve_point,
	input  logic signed [cli_pkg::VAL_W-1:0]    coordinate,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [cli_pkg::VAL_W-1:0]    interpolated_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cli_pkg::PIU_W-1:0]           cfg_data
);

	import cli_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	cli_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.op         (op),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	cli_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_data           (cfg_data),
		.entry_index        (entry_index),
		.axis_point         (axis_point),
		.curve_point        (curve_point),
		.coordinate         (coordinate),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.interpolated_value (interpolated_value)
	);

endmodule
